FILE: rtl/hlfr_pkg.sv
// shared types and constants of the header/length frame receiver
package hlfr_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RELOAD_W    = 16;
    localparam int unsigned DONE_SLOT_W = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned LEN_W       = BYTE_W + 1;

    // position of the length byte inside a frame
    localparam int unsigned LEN_POS = 2;

    // register reset values
    localparam logic [BYTE_W-1:0]   HEADER_RESET = 8'hAA;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'hFB7F;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BYTE    = 1'b0,
        CFG_TIMEOUT_RELOAD = 1'b1
    } cfg_idx_t;

    // one classified byte waiting in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              hdr_match;
    } item_t;

    // one result item
    typedef struct packed {
        logic                   frame_done;
        logic [DONE_SLOT_W-1:0] done_slot;
        logic                   timer_start;
        logic [RELOAD_W-1:0]    timer_load;
        logic                   timer_stop;
        logic                   bad_header;
        logic                   overflow;
    } result_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } back_state_t;

endpackage

FILE: rtl/hlfr_queue.sv
// two-entry queue between the front and back ends
module hlfr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hlfr_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output hlfr_pkg::item_t  head_item
);

    hlfr_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/hlfr_front.sv
// front end: takes received bytes and tags header matches
module hlfr_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hlfr_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic [hlfr_pkg::BYTE_W-1:0]   header_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output hlfr_pkg::item_t               q_item
);

    // accept while the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify against the header register
    always_comb begin
        q_item.rx_byte   = s_rx_byte;
        q_item.hdr_match = (s_rx_byte == header_byte);
    end

endmodule

FILE: rtl/hlfr_back.sv
// back end: frame state, slot buffer memory and result register
module hlfr_back #(
    parameter int unsigned SLOT_COUNT = 10,
    parameter int unsigned SLOT_BYTES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_not_empty,
    input  hlfr_pkg::item_t                 q_item,
    output logic                            q_pop,
    input  logic [hlfr_pkg::RELOAD_W-1:0]   timeout_reload,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hlfr_pkg::result_t               out_result
);

    localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned POS_W  = $clog2(SLOT_BYTES);
    localparam int unsigned DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned LEN_W  = hlfr_pkg::LEN_W;
    localparam logic [LEN_W-1:0]  LAST_MAX  = LEN_W'(SLOT_BYTES - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [POS_W-1:0]  POS_LEN   = POS_W'(hlfr_pkg::LEN_POS);
    localparam logic [ADDR_W-1:0] MEM_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] SLOT_TAIL = ADDR_W'(SLOT_BYTES - 1);

    // slot buffers
    logic [hlfr_pkg::BYTE_W-1:0] mem [DEPTH];

    hlfr_pkg::back_state_t state_reg;
    hlfr_pkg::back_state_t state_next;

    logic [SLOT_W-1:0]           write_slot_reg;
    logic [SLOT_W-1:0]           write_slot_next;
    logic [POS_W-1:0]            byte_pos_reg;
    logic [POS_W-1:0]            byte_pos_next;
    logic                        in_frame_reg;
    logic                        in_frame_next;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic [ADDR_W-1:0]           clr_addr_next;
    logic [ADDR_W-1:0]           clr_last_reg;
    logic [ADDR_W-1:0]           clr_last_next;
    hlfr_pkg::item_t             item_reg;
    logic [hlfr_pkg::BYTE_W-1:0] len_rd_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    hlfr_pkg::result_t           out_result_reg;
    hlfr_pkg::result_t           res_next;

    logic [ADDR_W-1:0]           slot_base;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        wr_en;
    logic [hlfr_pkg::BYTE_W-1:0] wr_data;
    logic                        frame_active;
    logic [hlfr_pkg::BYTE_W-1:0] len_byte;
    logic [LEN_W-1:0]            last_pos;
    logic [LEN_W-1:0]            pos_ext;
    logic                        len_too_long;
    logic                        frame_end;

    // buffer addressing within the current slot
    assign slot_base = ADDR_W'(write_slot_reg * SLOT_BYTES);
    assign rd_addr   = slot_base + ADDR_W'(hlfr_pkg::LEN_POS);

    // frame decisions for the byte in hand
    always_comb begin
        frame_active = (byte_pos_reg == '0) ? item_reg.hdr_match : in_frame_reg;
        len_byte     = (byte_pos_reg == POS_LEN) ? item_reg.rx_byte : len_rd_reg;
        last_pos     = {1'b0, len_byte} + LEN_W'(hlfr_pkg::LEN_POS);
        pos_ext      = LEN_W'(byte_pos_reg);
        len_too_long = (byte_pos_reg == POS_LEN) && (last_pos > LAST_MAX);
        frame_end    = (byte_pos_reg >= POS_LEN) && (pos_ext == last_pos);
    end

    // sequencer: pop and read length byte, update state and result, clear buffers
    always_comb begin
        state_next      = state_reg;
        q_pop           = 1'b0;
        write_slot_next = write_slot_reg;
        byte_pos_next   = byte_pos_reg;
        in_frame_next   = in_frame_reg;
        clr_addr_next   = clr_addr_reg;
        clr_last_next   = clr_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        wr_en           = 1'b0;
        wr_addr         = slot_base + ADDR_W'(byte_pos_reg);
        wr_data         = item_reg.rx_byte;
        res_next        = '0;
        unique case (state_reg)
            hlfr_pkg::ST_IDLE: begin
                if (q_not_empty && (!out_valid_reg || out_ready)) begin
                    q_pop      = 1'b1;
                    state_next = hlfr_pkg::ST_EXEC;
                end
            end
            hlfr_pkg::ST_EXEC: begin
                state_next     = hlfr_pkg::ST_IDLE;
                wr_en          = 1'b1;
                out_valid_next = 1'b1;
                // bad header clears the slot: byte 0 here, the rest one per cycle
                if (byte_pos_reg == '0) begin
                    if (item_reg.hdr_match) begin
                        res_next.timer_start = 1'b1;
                        res_next.timer_load  = timeout_reload;
                    end else begin
                        res_next.bad_header = 1'b1;
                        wr_data             = '0;
                        clr_addr_next       = slot_base + ADDR_W'(1);
                        clr_last_next       = slot_base + SLOT_TAIL;
                        state_next          = hlfr_pkg::ST_CLEAR;
                    end
                end
                in_frame_next = frame_active;
                if (frame_active) begin
                    priority if (len_too_long) begin
                        res_next.overflow   = 1'b1;
                        res_next.timer_stop = 1'b1;
                        in_frame_next       = 1'b0;
                        byte_pos_next       = '0;
                    end else if (frame_end) begin
                        res_next.frame_done = 1'b1;
                        res_next.done_slot  = hlfr_pkg::DONE_SLOT_W'(write_slot_reg);
                        res_next.timer_stop = 1'b1;
                        in_frame_next       = 1'b0;
                        byte_pos_next       = '0;
                        write_slot_next     = (write_slot_reg == SLOT_LAST) ? '0 :
                                              write_slot_reg + SLOT_W'(1);
                    end else begin
                        byte_pos_next = byte_pos_reg + POS_W'(1);
                    end
                end
            end
            hlfr_pkg::ST_CLEAR: begin
                // zero one buffer byte per cycle up to the end of the range
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == clr_last_reg) begin
                    state_next = hlfr_pkg::ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            default: begin
                state_next = hlfr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state, reset starts a clearing pass over all buffers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hlfr_pkg::ST_CLEAR;
            write_slot_reg <= '0;
            byte_pos_reg   <= '0;
            in_frame_reg   <= 1'b0;
            clr_addr_reg   <= '0;
            clr_last_reg   <= MEM_LAST;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            byte_pos_reg   <= byte_pos_next;
            in_frame_reg   <= in_frame_next;
            clr_addr_reg   <= clr_addr_next;
            clr_last_reg   <= clr_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (state_reg == hlfr_pkg::ST_EXEC) begin
            out_result_reg <= res_next;
        end
    end

    // slot buffer: registered read of the length byte, one write port
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            len_rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

FILE: rtl/header_length_frame_receiver.sv
// top level of the header/length frame receiver
//
// Receives one serial byte per transfer and stores it into a ring of
// SLOT_COUNT buffers of SLOT_BYTES bytes. A frame starts with a byte equal
// to header_byte (the result then asks the timeout timer to start with
// timeout_reload), byte 2 holds the length L and the frame completes at
// position L+2; a length that would run past the slot gives overflow and the
// frame is dropped. A byte at position 0 that is not the header clears the
// whole slot. Every input byte yields exactly one result. Bytes enter a
// two-entry queue; the back end handles each byte in ST_IDLE, which pops it
// and reads the stored length byte, then in ST_EXEC, which updates the frame
// state and loads the result register. It takes a new byte only after it is
// through with the last one and while its result register is free or being
// taken. A bad header holds the back end in ST_CLEAR while it zeroes the
// rest of the slot. After reset the back end first zeroes all buffer bytes,
// SLOT_COUNT*SLOT_BYTES of them (160 with the default sizes), before it
// takes the first byte from the queue; the queue fills meanwhile and
// then holds off the input. Configuration writes are accepted at any cycle
// and must only be made while no byte is in flight.
module header_length_frame_receiver #(
    parameter int unsigned SLOT_COUNT = 10,
    parameter int unsigned SLOT_BYTES = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [hlfr_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_frame_done,
    output logic [hlfr_pkg::DONE_SLOT_W-1:0]     m_done_slot,
    output logic                                 m_timer_start,
    output logic [hlfr_pkg::RELOAD_W-1:0]        m_timer_load,
    output logic                                 m_timer_stop,
    output logic                                 m_bad_header,
    output logic                                 m_overflow,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hlfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hlfr_pkg::RELOAD_W-1:0]        cfg_data
);

    logic [hlfr_pkg::BYTE_W-1:0]   header_byte_reg;
    logic [hlfr_pkg::RELOAD_W-1:0] timeout_reload_reg;
    logic                          q_full;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_not_empty;
    hlfr_pkg::item_t               q_in_item;
    hlfr_pkg::item_t               q_head_item;
    hlfr_pkg::result_t             result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg    <= hlfr_pkg::HEADER_RESET;
            timeout_reload_reg <= hlfr_pkg::RELOAD_RESET;
        end else if (cfg_valid) begin
            unique case (hlfr_pkg::cfg_idx_t'(cfg_index))
                hlfr_pkg::CFG_HEADER_BYTE: begin
                    header_byte_reg <= cfg_data[hlfr_pkg::BYTE_W-1:0];
                end
                hlfr_pkg::CFG_TIMEOUT_RELOAD: begin
                    timeout_reload_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // front end
    hlfr_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .header_byte (header_byte_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    // queue between front and back
    hlfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    // back end
    hlfr_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_item         (q_head_item),
        .q_pop          (q_pop),
        .timeout_reload (timeout_reload_reg),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_result     (result)
    );

    // result ports
    assign m_frame_done  = result.frame_done;
    assign m_done_slot   = result.done_slot;
    assign m_timer_start = result.timer_start;
    assign m_timer_load  = result.timer_load;
    assign m_timer_stop  = result.timer_stop;
    assign m_bad_header  = result.bad_header;
    assign m_overflow    = result.overflow;

    // a completed frame is never also dropped
    a_done_not_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_done && m_overflow))
        else $error("frame_done and overflow in one result");

    // a frame start cannot end the frame on the same byte
    a_start_not_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timer_start) |-> (!m_timer_stop && !m_bad_header))
        else $error("timer_start with timer_stop or bad_header");

    // queue never pops when empty
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule
